>>> hw/rtl/assert_macros.svh
// assertion helpers shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property checked at every clock edge outside reset
`define PWFD_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("pwfd assertion failed");

// same-cycle implication
`define PWFD_ASSERT_IMP(lbl, clk, rst, a, b) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("pwfd assertion failed");

// next-cycle implication
`define PWFD_ASSERT_NEXT(lbl, clk, rst, a, b) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("pwfd assertion failed");

`endif

>>> hw/rtl/pwfd_pkg.sv
`default_nettype none
package pwfd_pkg;

  // field and register widths
  localparam int unsigned GAIN_W     = 32;
  localparam int unsigned LIMIT_W    = 47;
  localparam int unsigned TAU_W      = 24;
  localparam int unsigned ERR_W      = 24;
  localparam int unsigned STEP_W     = 16;
  localparam int unsigned SCALE_W    = 16;
  localparam int unsigned OUT_W      = 48;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 47;
  localparam int unsigned WORD_W     = 64;
  localparam int unsigned MUL_Y_W    = 33;
  localparam int unsigned DIVISOR_W  = 32;
  localparam int unsigned ALPHA_W    = 17;

  localparam logic [TAU_W-1:0] TAU_RESET = 24'd7958;

  // divide by 1000 through 16-bit digits: floor(x / 1000) = (x * K_RECIP) >> K_SHIFT
  // for every x below 2^26
  localparam logic [9:0]  K_DIV    = 10'd1000;
  localparam logic [26:0] K_RECIP  = 27'd68719477;
  localparam int unsigned K_SHIFT  = 36;

  // saturation bounds
  localparam logic signed [WORD_W-1:0] SAT62   = 64'sh4000_0000_0000_0000;
  localparam logic signed [WORD_W-1:0] SAT60   = 64'sh1000_0000_0000_0000;
  localparam logic signed [WORD_W-1:0] SAT46   = 64'sh0000_4000_0000_0000;
  localparam logic signed [WORD_W-1:0] OUT_MAX = 64'sh0000_7FFF_FFFF_FFFF;
  localparam logic signed [WORD_W-1:0] OUT_MIN = -64'sh0000_8000_0000_0000;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAIN_P    = 3'd0,
    REG_GAIN_I    = 3'd1,
    REG_GAIN_D    = 3'd2,
    REG_INT_LIMIT = 3'd3,
    REG_TAU       = 3'd4
  } cfg_reg_t;

  // rounding shift applied after a multiply
  typedef enum logic [1:0] {
    RND_NONE,
    RND_8,
    RND_14,
    RND_16
  } rnd_t;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_D_ALPHA,
    ST_D_RAW_MUL,
    ST_D_RAW_DIV,
    ST_D_FILT,
    ST_D_GAIN,
    ST_P_MUL,
    ST_S_MUL,
    ST_I_MUL_A,
    ST_I_MUL_B,
    ST_I_DIV,
    ST_FINISH
  } state_t;

  // multiplier control from the sequencer
  typedef struct packed {
    logic start;
    rnd_t rnd;
  } mul_ctl_t;

  function automatic logic signed [WORD_W-1:0] clamp64(
    input logic signed [WORD_W-1:0] v,
    input logic signed [WORD_W-1:0] lo,
    input logic signed [WORD_W-1:0] hi
  );
    logic signed [WORD_W-1:0] r;
    if (v < lo) r = lo;
    else if (v > hi) r = hi;
    else r = v;
    return r;
  endfunction

  function automatic logic [WORD_W-1:0] magn64(input logic signed [WORD_W-1:0] v);
    logic [WORD_W-1:0] r;
    r = v[WORD_W-1] ? WORD_W'(-v) : WORD_W'(v);
    return r;
  endfunction

endpackage
`default_nettype wire

>>> hw/rtl/pid_with_filtered_derivative.sv
// channel  | handshake                | payload
// ---------+--------------------------+--------------------------------------------
// in       | in_valid / in_stall      | cmd, error_value, step_ms, scale_factor
// out      | out_valid / out_stall    | drive_value
// cfg      | cfg_write (no wait)      | cfg_index, cfg_data
//
// a clear result goes from ST_FINISH into the output register once the output is free.
// an update result follows the multiplies on the shared 32x32 multiplier, the
// coefficient and raw derivative divisions on the bit-serial divider, and the
// divide by 1000 in 16-bit digits.
// synchronous reset clears control state and history; configuration registers get reset values.
// the next transaction is taken while a result waits in the output register.
`default_nettype none
`include "assert_macros.svh"
module pid_with_filtered_derivative (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  cfg_write,
  input  wire logic [pwfd_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire logic [pwfd_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  wire logic                                  in_valid,
  output logic                                       in_stall,
  input  wire logic                                  cmd,
  input  wire logic signed [pwfd_pkg::ERR_W-1:0]     error_value,
  input  wire logic [pwfd_pkg::STEP_W-1:0]           step_ms,
  input  wire logic [pwfd_pkg::SCALE_W-1:0]          scale_factor,
  output logic                                       out_valid,
  input  wire logic                                  out_stall,
  output logic signed [pwfd_pkg::OUT_W-1:0]          drive_value
);

  // configuration registers
  logic signed [pwfd_pkg::GAIN_W-1:0]  gain_p;
  logic signed [pwfd_pkg::GAIN_W-1:0]  gain_i;
  logic signed [pwfd_pkg::GAIN_W-1:0]  gain_d;
  logic [pwfd_pkg::LIMIT_W-1:0]        integrator_limit;
  logic [pwfd_pkg::TAU_W-1:0]          tau;

  // controller history
  logic signed [pwfd_pkg::OUT_W-1:0]   integrator;
  logic signed [pwfd_pkg::ERR_W-1:0]   previous_error;
  logic signed [pwfd_pkg::OUT_W-1:0]   previous_derivative;

  // captured transaction and working registers
  logic signed [pwfd_pkg::ERR_W-1:0]   e_r;
  logic [pwfd_pkg::STEP_W-1:0]         step_r;
  logic [pwfd_pkg::SCALE_W-1:0]        scale_r;
  logic [pwfd_pkg::ALPHA_W-1:0]        alpha;
  logic signed [pwfd_pkg::WORD_W-1:0]  work;
  logic signed [pwfd_pkg::WORD_W-1:0]  d16;
  logic signed [pwfd_pkg::WORD_W-1:0]  res;

  pwfd_pkg::state_t state;
  pwfd_pkg::state_t state_next;
  logic             issued;
  logic             issued_next;

  // shared units
  pwfd_pkg::mul_ctl_t                  mul_ctl;
  logic signed [pwfd_pkg::WORD_W-1:0]  mul_x;
  logic signed [pwfd_pkg::MUL_Y_W-1:0] mul_y;
  logic signed [pwfd_pkg::WORD_W-1:0]  mul_result;
  logic                                mul_done;
  logic                                div_start;
  logic                                div_const;
  logic [pwfd_pkg::WORD_W-1:0]         div_num;
  logic [pwfd_pkg::DIVISOR_W-1:0]      div_den;
  logic [pwfd_pkg::WORD_W-1:0]         div_q;
  logic                                div_done;
  logic                                unit_done;

  // derived values
  logic [26:0]                         dt_us;
  logic [26:0]                         den;
  logic signed [24:0]                  err_diff;
  logic signed [pwfd_pkg::WORD_W-1:0]  diff_c;
  logic signed [pwfd_pkg::WORD_W-1:0]  nd_c;
  logic signed [pwfd_pkg::WORD_W-1:0]  inc;
  logic signed [pwfd_pkg::WORD_W-1:0]  lim;
  logic signed [pwfd_pkg::WORD_W-1:0]  integ_c;
  logic                                accept;
  logic                                do_d;
  logic                                do_i;
  logic                                out_free;

  assign accept    = in_valid && !in_stall;
  assign in_stall  = (state != pwfd_pkg::ST_IDLE);
  assign do_d      = (gain_d != '0) && (step_ms != '0);
  assign do_i      = (gain_i != '0) && (step_r != '0);
  assign out_free  = !out_valid || !out_stall;
  assign unit_done = mul_done || div_done;

  // filter coefficient terms and clamps
  assign dt_us    = 27'(step_r) * 27'd1000;
  assign den      = 27'(tau) + dt_us;
  assign err_diff = 25'(e_r) - 25'(previous_error);
  assign diff_c   = pwfd_pkg::clamp64(work - 64'(previous_derivative),
                                      -pwfd_pkg::SAT46, pwfd_pkg::SAT46);
  assign nd_c     = pwfd_pkg::clamp64(64'(previous_derivative) + mul_result,
                                      pwfd_pkg::OUT_MIN, pwfd_pkg::OUT_MAX);
  assign inc      = work[63] ? -$signed(div_q) : $signed(div_q);
  assign lim      = $signed(64'(integrator_limit));
  assign integ_c  = pwfd_pkg::clamp64(64'(integrator) + inc, -lim, lim);

  pwfd_mul u_mul (
    .clk    (clk),
    .rst    (rst),
    .ctl    (mul_ctl),
    .x      (mul_x),
    .y      (mul_y),
    .result (mul_result),
    .done   (mul_done)
  );

  pwfd_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .by_const (div_const),
    .dividend (div_num),
    .divisor  (div_den),
    .quotient (div_q),
    .done     (div_done)
  );

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= pwfd_pkg::ST_IDLE;
      issued <= 1'b0;
    end else begin
      state  <= state_next;
      issued <= issued_next;
    end
  end

  // sequencer: next state and unit operands
  always_comb begin
    state_next    = state;
    issued_next   = issued;
    mul_ctl.start = 1'b0;
    mul_ctl.rnd   = pwfd_pkg::RND_NONE;
    mul_x         = '0;
    mul_y         = '0;
    div_start     = 1'b0;
    div_const     = 1'b0;
    div_num       = '0;
    div_den       = '0;
    unique case (state)
      pwfd_pkg::ST_IDLE: begin
        if (accept) begin
          if (cmd) state_next = pwfd_pkg::ST_FINISH;
          else if (do_d) state_next = pwfd_pkg::ST_D_ALPHA;
          else state_next = pwfd_pkg::ST_P_MUL;
        end
      end
      pwfd_pkg::ST_D_ALPHA: begin
        div_num = 64'({dt_us, 16'b0}) + 64'(den >> 1);
        div_den = 32'(den);
      end
      pwfd_pkg::ST_D_RAW_MUL: begin
        mul_x = 64'(err_diff);
        mul_y = 33'sd256000;
      end
      pwfd_pkg::ST_D_RAW_DIV: begin
        div_num = pwfd_pkg::magn64(work) + 64'(step_r >> 1);
        div_den = 32'(step_r);
      end
      pwfd_pkg::ST_D_FILT: begin
        mul_x       = diff_c;
        mul_y       = 33'(alpha);
        mul_ctl.rnd = pwfd_pkg::RND_16;
      end
      pwfd_pkg::ST_D_GAIN: begin
        mul_x       = 64'(previous_derivative);
        mul_y       = 33'(gain_d);
        mul_ctl.rnd = pwfd_pkg::RND_8;
      end
      pwfd_pkg::ST_P_MUL: begin
        mul_x = 64'(e_r);
        mul_y = 33'(gain_p);
      end
      pwfd_pkg::ST_S_MUL: begin
        mul_x       = work;
        mul_y       = 33'(scale_r);
        mul_ctl.rnd = pwfd_pkg::RND_14;
      end
      pwfd_pkg::ST_I_MUL_A: begin
        mul_x = 64'(e_r);
        mul_y = 33'(gain_i);
      end
      pwfd_pkg::ST_I_MUL_B: begin
        mul_x       = work;
        mul_y       = 33'(32'(scale_r) * 32'(step_r));
        mul_ctl.rnd = pwfd_pkg::RND_14;
      end
      pwfd_pkg::ST_I_DIV: begin
        div_num   = pwfd_pkg::magn64(work) + 64'(pwfd_pkg::K_DIV >> 1);
        div_const = 1'b1;
      end
      pwfd_pkg::ST_FINISH: begin
        if (out_free) state_next = pwfd_pkg::ST_IDLE;
      end
      default: state_next = pwfd_pkg::ST_IDLE;
    endcase

    // issue the unit once, then wait for its done
    if (state != pwfd_pkg::ST_IDLE && state != pwfd_pkg::ST_FINISH) begin
      if (!issued) begin
        issued_next = 1'b1;
        if (state == pwfd_pkg::ST_D_ALPHA || state == pwfd_pkg::ST_D_RAW_DIV ||
            state == pwfd_pkg::ST_I_DIV) begin
          div_start = 1'b1;
        end else begin
          mul_ctl.start = 1'b1;
        end
      end else if (unit_done) begin
        issued_next = 1'b0;
        unique case (state)
          pwfd_pkg::ST_D_ALPHA:   state_next = pwfd_pkg::ST_D_RAW_MUL;
          pwfd_pkg::ST_D_RAW_MUL: state_next = pwfd_pkg::ST_D_RAW_DIV;
          pwfd_pkg::ST_D_RAW_DIV: state_next = pwfd_pkg::ST_D_FILT;
          pwfd_pkg::ST_D_FILT:    state_next = pwfd_pkg::ST_D_GAIN;
          pwfd_pkg::ST_D_GAIN:    state_next = pwfd_pkg::ST_P_MUL;
          pwfd_pkg::ST_P_MUL:     state_next = pwfd_pkg::ST_S_MUL;
          pwfd_pkg::ST_S_MUL:
            state_next = do_i ? pwfd_pkg::ST_I_MUL_A : pwfd_pkg::ST_FINISH;
          pwfd_pkg::ST_I_MUL_A:   state_next = pwfd_pkg::ST_I_MUL_B;
          pwfd_pkg::ST_I_MUL_B:   state_next = pwfd_pkg::ST_I_DIV;
          default:                state_next = pwfd_pkg::ST_FINISH;
        endcase
      end
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      gain_p           <= '0;
      gain_i           <= '0;
      gain_d           <= '0;
      integrator_limit <= '0;
      tau              <= pwfd_pkg::TAU_RESET;
    end else if (cfg_write) begin
      unique case (pwfd_pkg::cfg_reg_t'(cfg_index))
        pwfd_pkg::REG_GAIN_P:    gain_p <= cfg_data[31:0];
        pwfd_pkg::REG_GAIN_I:    gain_i <= cfg_data[31:0];
        pwfd_pkg::REG_GAIN_D:    gain_d <= cfg_data[31:0];
        pwfd_pkg::REG_INT_LIMIT: integrator_limit <= cfg_data;
        pwfd_pkg::REG_TAU:       tau <= cfg_data[23:0];
        default: ;
      endcase
    end
  end

  // history registers
  always_ff @(posedge clk) begin
    if (rst) begin
      integrator          <= '0;
      previous_error      <= '0;
      previous_derivative <= '0;
    end else if (state == pwfd_pkg::ST_IDLE && accept && cmd) begin
      integrator          <= '0;
      previous_error      <= '0;
      previous_derivative <= '0;
    end else if (issued && unit_done) begin
      if (state == pwfd_pkg::ST_D_FILT) begin
        previous_derivative <= 48'(nd_c);
        previous_error      <= e_r;
      end
      if (state == pwfd_pkg::ST_I_DIV) integrator <= 48'(integ_c);
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (state == pwfd_pkg::ST_IDLE && accept) begin
      e_r     <= error_value;
      step_r  <= step_ms;
      scale_r <= scale_factor;
      d16     <= '0;
      res     <= '0;
    end else if (issued && unit_done) begin
      unique case (state)
        pwfd_pkg::ST_D_ALPHA:   alpha <= div_q[16:0];
        pwfd_pkg::ST_D_RAW_MUL: work <= mul_result;
        pwfd_pkg::ST_D_RAW_DIV: work <= inc;
        pwfd_pkg::ST_D_GAIN:
          d16 <= pwfd_pkg::clamp64(mul_result, -pwfd_pkg::SAT60, pwfd_pkg::SAT60);
        pwfd_pkg::ST_P_MUL:     work <= mul_result + d16;
        pwfd_pkg::ST_S_MUL:     res <= mul_result;
        pwfd_pkg::ST_I_MUL_A:   work <= mul_result;
        pwfd_pkg::ST_I_MUL_B:   work <= mul_result;
        pwfd_pkg::ST_I_DIV:     res <= res + integ_c;
        default: ;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == pwfd_pkg::ST_FINISH && out_free) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == pwfd_pkg::ST_FINISH && out_free) begin
      drive_value <= 48'(pwfd_pkg::clamp64(res, pwfd_pkg::OUT_MIN, pwfd_pkg::OUT_MAX));
    end
  end

  // checks
  `PWFD_ASSERT(a_one_unit, clk, rst, !(mul_ctl.start && div_start))
  `PWFD_ASSERT_IMP(a_done_expected, clk, rst, mul_done || div_done, issued)
  `PWFD_ASSERT_IMP(a_alpha_range, clk, rst, state == pwfd_pkg::ST_D_FILT, alpha <= 17'd65536)
  `PWFD_ASSERT_NEXT(a_clear_history, clk, rst, accept && cmd, integrator == '0 && previous_derivative == '0 && previous_error == '0)
  `PWFD_ASSERT_NEXT(a_integ_clamp, clk, rst, state == pwfd_pkg::ST_I_DIV && issued && div_done, 64'(integrator) <= lim && 64'(integrator) >= -lim)

endmodule
`default_nettype wire

>>> hw/rtl/pwfd_mul.sv
`default_nettype none
module pwfd_mul (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire pwfd_pkg::mul_ctl_t                 ctl,
  input  wire logic signed [pwfd_pkg::WORD_W-1:0]  x,
  input  wire logic signed [pwfd_pkg::MUL_Y_W-1:0] y,
  output logic signed [pwfd_pkg::WORD_W-1:0]       result,
  output logic                                    done
);

  logic [63:0]    xmag;
  logic [31:0]    ymag;
  logic           neg;
  pwfd_pkg::rnd_t rnd;
  logic [95:0]    acc;
  logic           lo_v;
  logic           hi_v;
  logic           rd_v;
  logic [31:0]    op_a;
  logic [63:0]    prod;
  logic [96:0]    rsum;
  logic [96:0]    shifted;
  logic [63:0]    mag_sat;

  // one 32x32 partial product per cycle
  assign op_a = lo_v ? xmag[31:0] : xmag[63:32];
  assign prod = op_a * ymag;

  // round to nearest, ties away from zero, then saturate at 2^62
  always_comb begin
    rsum    = {1'b0, acc};
    shifted = {1'b0, acc};
    unique case (rnd)
      pwfd_pkg::RND_NONE: begin
        rsum    = {1'b0, acc};
        shifted = rsum;
      end
      pwfd_pkg::RND_8: begin
        rsum    = {1'b0, acc} + 97'd128;
        shifted = rsum >> 8;
      end
      pwfd_pkg::RND_14: begin
        rsum    = {1'b0, acc} + 97'd8192;
        shifted = rsum >> 14;
      end
      pwfd_pkg::RND_16: begin
        rsum    = {1'b0, acc} + 97'd32768;
        shifted = rsum >> 16;
      end
      default: begin
        rsum    = {1'b0, acc};
        shifted = rsum;
      end
    endcase
    mag_sat = (shifted > 97'(pwfd_pkg::SAT62)) ? 64'(pwfd_pkg::SAT62) : shifted[63:0];
  end

  // control flags
  always_ff @(posedge clk) begin
    if (rst) begin
      lo_v <= 1'b0;
      hi_v <= 1'b0;
      rd_v <= 1'b0;
      done <= 1'b0;
    end else begin
      lo_v <= ctl.start;
      hi_v <= lo_v;
      rd_v <= hi_v;
      done <= rd_v;
    end
  end

  // operand capture and accumulation
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      xmag <= pwfd_pkg::magn64(x);
      ymag <= y[32] ? 32'(-y) : y[31:0];
      neg  <= x[63] ^ y[32];
      rnd  <= ctl.rnd;
    end
    if (lo_v) acc <= {32'b0, prod};
    if (hi_v) acc <= acc + {prod, 32'b0};
    if (rd_v) result <= neg ? -$signed(mag_sat) : $signed(mag_sat);
  end

endmodule
`default_nettype wire

>>> hw/rtl/pwfd_div.sv
`default_nettype none
module pwfd_div (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  start,
  input  wire logic                                  by_const,
  input  wire logic [pwfd_pkg::WORD_W-1:0]           dividend,
  input  wire logic [pwfd_pkg::DIVISOR_W-1:0]        divisor,
  output logic [pwfd_pkg::WORD_W-1:0]                quotient,
  output logic                                       done
);

  logic        running;
  logic        const_mode;
  logic        last;
  logic [5:0]  count;
  logic [31:0] rem;
  logic [31:0] den;
  logic [32:0] shifted;
  logic        fits;
  logic [25:0] kx;
  logic [52:0] kprod;
  logic [15:0] kq;
  logic [25:0] krem;

  // one restoring step per cycle
  assign shifted = {rem, quotient[63]};
  assign fits    = shifted >= {1'b0, den};

  // divide by 1000: one 16-bit digit per cycle by reciprocal multiplication
  assign kx    = {rem[9:0], quotient[63:48]};
  assign kprod = 53'(kx) * 53'(pwfd_pkg::K_RECIP);
  assign kq    = 16'(kprod >> pwfd_pkg::K_SHIFT);
  assign krem  = kx - 26'(kq) * 26'(pwfd_pkg::K_DIV);

  assign last = const_mode ? (count == 6'd3) : (count == 6'd63);

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      count   <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        count   <= '0;
      end else if (running) begin
        count <= count + 6'd1;
        if (last) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  // remainder and quotient shift
  always_ff @(posedge clk) begin
    if (start) begin
      quotient   <= dividend;
      rem        <= '0;
      den        <= divisor;
      const_mode <= by_const;
    end else if (running) begin
      if (const_mode) begin
        rem      <= 32'(krem);
        quotient <= {quotient[47:0], kq};
      end else begin
        rem      <= fits ? 32'(shifted - {1'b0, den}) : shifted[31:0];
        quotient <= {quotient[62:0], fits};
      end
    end
  end

endmodule
`default_nettype wire
